// File: design/hex_pkg.sv
package hex_pkg;

  // Default block sizes
  localparam int CHANNELS_DEF    = 2;
  localparam int TANH_POINTS_DEF = 256;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_B0    = 3'd0;
  localparam logic [2:0] REG_A1    = 3'd1;
  localparam logic [2:0] REG_A2    = 3'd2;
  localparam logic [2:0] REG_DRIVE = 3'd3;
  localparam logic [2:0] REG_WET   = 3'd4;
  localparam logic [2:0] REG_ODD   = 3'd5;
  localparam logic [2:0] REG_RATE  = 3'd6;

  // Shared multiplier geometry: wide operand split into two halves
  localparam int MUL_AW    = 48;
  localparam int MUL_BW    = 33;
  localparam int MUL_SPLIT = 24;
  localparam int MUL_PW    = 81;

  // Fixed gains
  localparam logic [32:0] AP_SCALE   = 33'd214748365;  // 0.05 in Q0.32
  localparam logic [16:0] MIX_ONE    = 17'd65536;      // 1.0 in Q0.16
  localparam logic [39:0] TANH_LIMIT = 40'd67108864;   // 4.0 in Q.24

  // One step of the per-sample schedule, in order
  typedef enum logic [3:0] {
    OP_B0X,     // b0 * (x - x2)
    OP_A1Y1,    // a1 * y1
    OP_A2Y2,    // a2 * y2, closes the band value
    OP_A2BAND,  // a2 * band
    OP_A1P1,    // a1 * p1
    OP_A2P2,    // a2 * p2, closes the allpass value
    OP_SQ,      // band * band
    OP_DC,      // rate * (raw - dc)
    OP_DRV,     // band * drive
    OP_TANH,    // table interpolation
    OP_EVD,     // even * drive
    OP_EVM,     // even share of the mix
    OP_ODD,     // odd * mix
    OP_APS,     // allpass * 0.05
    OP_WET      // wet amount, closes the sample
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic wb;
    logic commit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } sts_t;

  typedef struct packed {
    logic [31:0] b0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [22:0] drive;
    logic [19:0] wet;
    logic [16:0] odd_share;
    logic [23:0] rate;
  } cfg_t;

endpackage

// File: design/harmonic_exciter_top.sv
// Harmonic exciter: each word carries one signed 24-bit sample and a channel number and
// gives one excited sample back with the same channel number. The sample runs through the
// channel's bandpass and allpass, an even harmonic (band squared less a tracked DC level)
// and an odd harmonic (interpolated tanh table), which are mixed and added to the dry
// input with saturation. Each sample is accepted, then fifteen products are formed in turn on
// one shared 25x33 multiplier, which builds every product from two half products and a sum.
// One sample is worked at a time; the next is taken as soon as the sequencer is idle, while
// the last result may still wait in the output register. Coefficients are to be written over
// the register port while idle; the block itself does not enforce this.
module harmonic_exciter_top import hex_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TANH_POINTS = TANH_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_chan,
  input  logic signed [23:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_sample_out,
  output logic               out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg_r, cfg_nxt;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  // Write the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_idx)
        REG_B0:    cfg_nxt.b0        = pwdata;
        REG_A1:    cfg_nxt.a1        = pwdata;
        REG_A2:    cfg_nxt.a2        = pwdata;
        REG_DRIVE: cfg_nxt.drive     = pwdata[22:0];
        REG_WET:   cfg_nxt.wet       = pwdata[19:0];
        REG_ODD:   cfg_nxt.odd_share = pwdata[16:0];
        REG_RATE:  cfg_nxt.rate      = pwdata[23:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0        <= '0;
      cfg_r.a1        <= '0;
      cfg_r.a2        <= '0;
      cfg_r.drive     <= 23'd65536;
      cfg_r.wet       <= '0;
      cfg_r.odd_share <= 17'd32768;
      cfg_r.rate      <= 24'd43690;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      REG_B0:    prdata = cfg_r.b0;
      REG_A1:    prdata = cfg_r.a1;
      REG_A2:    prdata = cfg_r.a2;
      REG_DRIVE: prdata = 32'(cfg_r.drive);
      REG_WET:   prdata = 32'(cfg_r.wet);
      REG_ODD:   prdata = 32'(cfg_r.odd_share);
      REG_RATE:  prdata = 32'(cfg_r.rate);
      default:   prdata = '0;
    endcase
  end

  hex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  hex_datapath #(
    .CHANNELS    (CHANNELS),
    .TANH_POINTS (TANH_POINTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg_r),
    .in_chan        (in_chan),
    .in_sample_in   (in_sample_in),
    .out_sample_out (out_sample_out),
    .out_chan       (out_chan)
  );

  // A word in work blocks the next one
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("input taken while a word is in work");

  // A finished sample shows up on the output
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("finished sample not presented");

  // Multiplier finish is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |=> !sts.mul_done)
    else $error("multiplier done held");

  // No new product starts while one completes
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_done)
    else $error("product started over a running one");

endmodule

// File: design/hex_mul.sv
module hex_mul import hex_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic                     done,
  output logic signed [MUL_PW-1:0] p
);

  typedef enum logic [1:0] {PH_IDLE, PH_HI, PH_SUM} phase_t;

  phase_t phase_r, phase_nxt;
  logic signed [MUL_SPLIT+MUL_BW:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [MUL_PW-1:0]         p_r, p_nxt;
  logic signed [MUL_SPLIT:0]        m_a;
  logic signed [MUL_SPLIT+MUL_BW:0] m_p;

  // Pick the low half (unsigned) first, then the signed high half
  always_comb begin
    if (phase_r == PH_HI) begin
      m_a = $signed({a[MUL_AW-1], a[MUL_AW-1:MUL_SPLIT]});
    end else begin
      m_a = $signed({1'b0, a[MUL_SPLIT-1:0]});
    end
    m_p = m_a * b;
  end

  // Advance the partial products and combine them
  always_comb begin
    phase_nxt = phase_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    p_nxt     = p_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          lo_nxt    = m_p;
          phase_nxt = PH_HI;
        end
      end
      PH_HI: begin
        hi_nxt    = m_p;
        phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        p_nxt     = (MUL_PW'(hi_r) <<< MUL_SPLIT) + MUL_PW'(lo_r);
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    p_r  <= p_nxt;
  end

  assign done = (phase_r == PH_SUM);
  assign p    = p_r;

endmodule

// File: design/hex_tanh_rom.sv
module hex_tanh_rom import hex_pkg::*; #(
  parameter int TANH_POINTS = TANH_POINTS_DEF
) (
  input  logic [$clog2(TANH_POINTS+1)-1:0] idx,
  output logic [15:0]                      ta,
  output logic [15:0]                      tb
);

  localparam int IW = $clog2(TANH_POINTS + 1);

  // Shift-subtract divide, evaluated while the table is built
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4k/n) in Q0.16 via e^-2x: series on the argument over 16, squared four times
  function automatic logic [15:0] tanh_entry(input logic [63:0] k, input logic [63:0] n);
    logic [63:0]        t;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        v;
    t    = udiv((k << 30) + n, n << 1);
    term = 64'd1 << 30;
    sum  = $signed(term);
    for (int i = 1; i <= 16; i++) begin
      term = (term * t + (64'd1 << 29)) >> 30;
      term = udiv(term + (64'(i) >> 1), 64'(i));
      if (i % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    e = (sum > 0) ? 64'(sum) : 64'd0;
    for (int s = 0; s < 4; s++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    num = (e < (64'd1 << 30)) ? (64'd1 << 30) - e : 64'd0;
    den = (64'd1 << 30) + e;
    v   = udiv((num << 16) + (den >> 1), den);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  logic [15:0] tbl [TANH_POINTS+1];

  // Build the constant table at elaboration
  for (genvar k = 0; k <= TANH_POINTS; k++) begin : g_tbl
    localparam logic [15:0] ENTRY = tanh_entry(64'(k), 64'(TANH_POINTS));
    assign tbl[k] = ENTRY;
  end

  // Read the two neighbors around the point
  assign ta = tbl[idx];
  assign tb = tbl[idx + IW'(1)];

endmodule

// File: design/hex_datapath.sv
module hex_datapath import hex_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TANH_POINTS = TANH_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  cfg_t               cfg,
  input  logic               in_chan,
  input  logic signed [23:0] in_sample_in,
  output logic signed [23:0] out_sample_out,
  output logic               out_chan
);

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW  = $clog2(TANH_POINTS + 1);
  localparam int QW  = 26 + IW;
  localparam int ACW = 46;

  function automatic logic signed [MUL_PW-1:0] rshr(input logic signed [MUL_PW-1:0] v,
                                                    input int unsigned n);
    logic signed [MUL_PW-1:0] half;
    half        = '0;
    half[n-1]   = 1'b1;
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MUL_PW-1:0] v);
    if (v[MUL_PW-1:31] == '0 || v[MUL_PW-1:31] == '1) begin
      return v[31:0];
    end
    return v[MUL_PW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [MUL_PW-1:0] v);
    if (v[MUL_PW-1:23] == '0 || v[MUL_PW-1:23] == '1) begin
      return v[23:0];
    end
    return v[MUL_PW-1] ? 24'sh800000 : 24'sh7FFFFF;
  endfunction

  // Per-channel filter state
  logic signed [23:0] bpi1_r [CHANNELS];
  logic signed [23:0] bpi2_r [CHANNELS];
  logic signed [31:0] bpo1_r [CHANNELS];
  logic signed [31:0] bpo2_r [CHANNELS];
  logic signed [31:0] apo1_r [CHANNELS];
  logic signed [31:0] apo2_r [CHANNELS];
  logic signed [31:0] dcl_r  [CHANNELS];

  // Working registers for one sample
  logic signed [23:0]     x_r, x_nxt;
  logic [CW-1:0]          c_r, c_nxt;
  logic                   chan_r, chan_nxt;
  logic signed [ACW-1:0]  acc_r, acc_nxt;
  logic signed [33:0]     t2_r, t2_nxt;
  logic signed [31:0]     band_r, band_nxt;
  logic signed [31:0]     ap_r, ap_nxt;
  logic signed [31:0]     raw_r, raw_nxt;
  logic signed [31:0]     dcn_r, dcn_nxt;
  logic signed [31:0]     even_r, even_nxt;
  logic signed [39:0]     u_r, u_nxt;
  logic signed [17:0]     odd_r, odd_nxt;
  logic signed [23:0]     y_r, y_nxt;
  logic                   ochan_r, ochan_nxt;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic                     mul_done;

  logic signed [23:0] x2;
  logic signed [31:0] y1, y2, p1, p2, dc_old;
  logic [16:0]        mix;

  logic [39:0]    mag;
  logic           tneg, tbig;
  logic [QW-1:0]  pos;
  logic [IW-1:0]  idx;
  logic [23:0]    frac;
  logic [15:0]    ta, tb;

  assign x2     = bpi2_r[c_r];
  assign y1     = bpo1_r[c_r];
  assign y2     = bpo2_r[c_r];
  assign p1     = apo1_r[c_r];
  assign p2     = apo2_r[c_r];
  assign dc_old = dcl_r[c_r];
  assign mix    = (cfg.odd_share > MIX_ONE) ? MIX_ONE : cfg.odd_share;

  // Locate the table point for |u|
  always_comb begin
    tneg = u_r[39];
    mag  = tneg ? 40'(-u_r) : 40'(u_r);
    tbig = (mag >= TANH_LIMIT);
    pos  = (QW'(mag[25:0]) * QW'(TANH_POINTS)) >> 2;
    frac = pos[23:0];
    idx  = IW'(pos >> 24);
    if (idx >= IW'(TANH_POINTS)) begin
      idx = IW'(TANH_POINTS - 1);
    end
  end

  hex_tanh_rom #(.TANH_POINTS(TANH_POINTS)) u_rom (
    .idx (idx),
    .ta  (ta),
    .tb  (tb)
  );

  // Route operands to the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_B0X: begin
        mul_a = MUL_AW'($signed(cfg.b0));
        mul_b = MUL_BW'(25'(x_r) - 25'(x2));
      end
      OP_A1Y1: begin
        mul_a = MUL_AW'($signed(cfg.a1));
        mul_b = MUL_BW'(y1);
      end
      OP_A2Y2: begin
        mul_a = MUL_AW'($signed(cfg.a2));
        mul_b = MUL_BW'(y2);
      end
      OP_A2BAND: begin
        mul_a = MUL_AW'($signed(cfg.a2));
        mul_b = MUL_BW'(band_r);
      end
      OP_A1P1: begin
        mul_a = MUL_AW'($signed(cfg.a1));
        mul_b = MUL_BW'(p1);
      end
      OP_A2P2: begin
        mul_a = MUL_AW'($signed(cfg.a2));
        mul_b = MUL_BW'(p2);
      end
      OP_SQ: begin
        mul_a = MUL_AW'(band_r);
        mul_b = MUL_BW'(band_r);
      end
      OP_DC: begin
        mul_a = $signed(MUL_AW'(cfg.rate));
        mul_b = MUL_BW'(raw_r) - MUL_BW'(dc_old);
      end
      OP_DRV: begin
        mul_a = MUL_AW'(band_r);
        mul_b = $signed(MUL_BW'(cfg.drive));
      end
      OP_TANH: begin
        mul_a = MUL_AW'($signed({1'b0, tb}) - $signed({1'b0, ta}));
        mul_b = $signed(MUL_BW'(frac));
      end
      OP_EVD: begin
        mul_a = MUL_AW'(even_r);
        mul_b = $signed(MUL_BW'(cfg.drive));
      end
      OP_EVM: begin
        mul_a = MUL_AW'(acc_r);
        mul_b = $signed(MUL_BW'(MIX_ONE)) - $signed(MUL_BW'(mix));
      end
      OP_ODD: begin
        mul_a = MUL_AW'(odd_r);
        mul_b = $signed(MUL_BW'(mix));
      end
      OP_APS: begin
        mul_a = MUL_AW'(ap_r);
        mul_b = $signed(AP_SCALE);
      end
      OP_WET: begin
        mul_a = MUL_AW'(acc_r);
        mul_b = $signed(MUL_BW'(cfg.wet));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hex_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (prod)
  );

  assign sts.mul_done = mul_done;

  // Load the word and fold each product into its destination
  always_comb begin
    logic signed [MUL_PW-1:0] r30;
    logic signed [MUL_PW-1:0] r24;
    logic signed [MUL_PW-1:0] r16;
    logic [16:0]              omag;

    x_nxt     = x_r;
    c_nxt     = c_r;
    chan_nxt  = chan_r;
    acc_nxt   = acc_r;
    t2_nxt    = t2_r;
    band_nxt  = band_r;
    ap_nxt    = ap_r;
    raw_nxt   = raw_r;
    dcn_nxt   = dcn_r;
    even_nxt  = even_r;
    u_nxt     = u_r;
    odd_nxt   = odd_r;
    y_nxt     = y_r;
    ochan_nxt = ochan_r;
    r30       = rshr(prod, 30);
    r24       = rshr(prod, 24);
    r16       = rshr(prod, 16);
    omag      = '0;

    if (cmd.load) begin
      x_nxt    = in_sample_in;
      chan_nxt = in_chan;
      c_nxt    = (CHANNELS > 1) ? CW'(in_chan) : '0;
    end

    if (cmd.wb) begin
      case (cmd.op)
        OP_B0X: acc_nxt = ACW'(rshr(prod, 29));
        OP_A1Y1: begin
          t2_nxt  = 34'(r30);
          acc_nxt = ACW'(MUL_PW'(acc_r) - r30);
        end
        OP_A2Y2:   band_nxt = sat32(MUL_PW'(acc_r) - r30);
        OP_A2BAND: acc_nxt  = ACW'(r30 + MUL_PW'(t2_r) + MUL_PW'(y2));
        OP_A1P1:   acc_nxt  = ACW'(MUL_PW'(acc_r) - r30);
        OP_A2P2:   ap_nxt   = sat32(MUL_PW'(acc_r) - r30);
        OP_SQ:     raw_nxt  = sat32(r24);
        OP_DC: begin
          dcn_nxt  = sat32(MUL_PW'(dc_old) + r24);
          even_nxt = sat32(MUL_PW'(raw_r) - MUL_PW'(dcn_nxt));
        end
        OP_DRV: u_nxt = 40'(r16);
        OP_TANH: begin
          omag    = tbig ? MIX_ONE : (17'(ta) + 17'(r24));
          odd_nxt = tneg ? -$signed({1'b0, omag}) : $signed({1'b0, omag});
        end
        OP_EVD:  acc_nxt = ACW'(r16);
        OP_EVM:  acc_nxt = ACW'(r16);
        OP_ODD:  acc_nxt = ACW'(MUL_PW'(acc_r) + rshr(prod, 8));
        OP_APS:  acc_nxt = ACW'(MUL_PW'(acc_r) + rshr(prod, 32));
        OP_WET: begin
          y_nxt     = sat24(MUL_PW'(x_r) + rshr(prod, 17));
          ochan_nxt = chan_r;
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    c_r     <= c_nxt;
    chan_r  <= chan_nxt;
    acc_r   <= acc_nxt;
    t2_r    <= t2_nxt;
    band_r  <= band_nxt;
    ap_r    <= ap_nxt;
    raw_r   <= raw_nxt;
    dcn_r   <= dcn_nxt;
    even_r  <= even_nxt;
    u_r     <= u_nxt;
    odd_r   <= odd_nxt;
    y_r     <= y_nxt;
    ochan_r <= ochan_nxt;
  end

  // Shift the channel history once the sample is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        bpi1_r[i] <= '0;
        bpi2_r[i] <= '0;
        bpo1_r[i] <= '0;
        bpo2_r[i] <= '0;
        apo1_r[i] <= '0;
        apo2_r[i] <= '0;
        dcl_r[i]  <= '0;
      end
    end else if (cmd.commit) begin
      bpi2_r[c_r] <= bpi1_r[c_r];
      bpi1_r[c_r] <= x_r;
      bpo2_r[c_r] <= bpo1_r[c_r];
      bpo1_r[c_r] <= band_r;
      apo2_r[c_r] <= apo1_r[c_r];
      apo1_r[c_r] <= ap_r;
      dcl_r[c_r]  <= dcn_r;
    end
  end

  assign out_sample_out = y_r;
  assign out_chan       = ochan_r;

endmodule

// File: design/hex_ctrl.sv
module hex_ctrl import hex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_WB} state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands for the datapath
  always_comb begin
    cmd.load      = in_valid && (state_r == S_IDLE);
    cmd.mul_start = (state_r == S_ISSUE);
    cmd.commit    = (state_r == S_WB) && (op_r == OP_WET) && slot_free;
    cmd.wb        = (state_r == S_WB) && ((op_r != OP_WET) || slot_free);
    cmd.op        = op_r;
  end

  // Step through the schedule, one product at a time
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          op_nxt    = OP_B0X;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (op_r == OP_WET) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          op_nxt    = op_t'(op_r + 4'd1);
          state_nxt = S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_B0X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
